### src/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg
// Shared constants and codes for the spanning tree route walk.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int MAX_NODES   = 32;
  localparam int ROUTE_SLOTS = 64;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int SLOT_W  = $clog2(ROUTE_SLOTS);
  localparam int CNT_W   = $clog2(ROUTE_SLOTS + 1);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int WGT_W   = 16;
  localparam int HOP_W   = 2 * NODE_W;
  localparam int FRAME_W = 2 * NODE_W + NCNT_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // walk status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_SPLIT = 2'd2;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

endpackage

### src/stw_ram.sv
// ----------------------------------------------------------------------------
// stw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/spanning_tree_route_walk.sv
// ----------------------------------------------------------------------------
// spanning_tree_route_walk
// Edge matrix store with a depth-first route walk and route list readout.
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tuser opcode; tdata row, col, weight
// m_axis    out        tuser route_valid; tdata hop fields; tlast end_of_list
// cfg       in         node_count, written with cfg_wr_en_i
//
// A weight write reads the edge row, then merges the edge bit and writes the
// row back.
// A start item scans every row for pending nodes, then walks the tree one
// matrix column at a time per tree node, loading a row on each descent and
// reloading the parent frame on each return, then emits the route items.
// Reset clears only control and per-row valid bits; rows never written read
// as no edges. A stalled output holds the block; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module spanning_tree_route_walk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // opcode
  input  logic [31:0] s_axis_tdata,   // row_node, col_node, edge_weight, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // route_valid
  output logic [23:0] m_axis_tdata,   // route_index, route_source,
                                      // route_destination, is_last_round_trip,
                                      // walk_status, zero pad
  output logic        m_axis_tlast    // end_of_list
);

  localparam int NW = stw_pkg::NODE_W;
  localparam int SW = stw_pkg::SLOT_W;
  localparam int CW = stw_pkg::CNT_W;
  localparam int KW = stw_pkg::NCNT_W;
  localparam int MN = stw_pkg::MAX_NODES;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WR_MOD, ST_PEND_RD, ST_PEND_ACC, ST_LOAD, ST_SCAN,
    ST_RET, ST_POP, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
  } state_e;

  state_e state_q, state_d;

  logic [5:0]    cfg_q, cfg_d;
  logic [NW-1:0] wr_row_q, wr_row_d, wr_col_q, wr_col_d;
  logic          wr_pos_q, wr_pos_d;
  logic [MN-1:0] row_vld_q, row_vld_d;
  logic [NW-1:0] erow_q, erow_d;
  logic [MN-1:0] pend_q, pend_d;
  logic [KW-1:0] scan_q, scan_d;
  logic [NW-1:0] here_q, here_d, from_q, from_d;
  logic [KW-1:0] jidx_q, jidx_d, depth_q, depth_d;
  logic [MN-1:0] row_q, row_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MN-1:0] seen_q, seen_d;
  logic [SW-1:0] last_q, last_d, k_q, k_d;
  logic [1:0]    status_q, status_d;
  logic          m_valid_q, m_valid_d, m_user_q, m_user_d, m_last_q, m_last_d;
  logic [23:0]   m_data_q, m_data_d;

  // memory ports
  logic                          edge_we;
  logic [NW-1:0]                 edge_waddr, edge_raddr;
  logic [MN-1:0]                 edge_wdata, edge_rdata, edge_row;
  logic                          route_we;
  logic [SW-1:0]                 route_waddr, route_raddr;
  logic [stw_pkg::HOP_W-1:0]     route_wdata, route_rdata;
  logic                          stk_we;
  logic [NW-1:0]                 stk_waddr, stk_raddr;
  logic [stw_pkg::FRAME_W-1:0]   stk_wdata, stk_rdata;

  // hop push request
  logic          push_en;
  logic [NW-1:0] push_src, push_dst;

  logic [KW-1:0] n_act;
  logic [NW-1:0] jn;
  logic          room, cand;
  logic [CW-1:0] k_next;

  assign n_act    = (cfg_q > 6'(MN)) ? KW'(MN) : KW'(cfg_q);
  assign jn       = jidx_q[NW-1:0];
  assign room     = cnt_q < CW'(stw_pkg::ROUTE_SLOTS);
  assign cand     = row_q[jn] && pend_q[jn] && ((depth_q == '0) || (jn != from_q));
  assign edge_row = row_vld_q[erow_q] ? edge_rdata : '0;
  assign k_next   = CW'(k_q) + CW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  stw_ram #(.WIDTH(MN), .DEPTH(MN)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  stw_ram #(.WIDTH(stw_pkg::HOP_W), .DEPTH(stw_pkg::ROUTE_SLOTS)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (route_waddr),
    .wdata_i (route_wdata),
    .raddr_i (route_raddr),
    .rdata_o (route_rdata)
  );

  stw_ram #(.WIDTH(stw_pkg::FRAME_W), .DEPTH(MN)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    cfg_d     = cfg_wr_en_i ? cfg_wr_data_i : cfg_q;
    wr_row_d  = wr_row_q;
    wr_col_d  = wr_col_q;
    wr_pos_d  = wr_pos_q;
    row_vld_d = row_vld_q;
    erow_d    = erow_q;
    pend_d    = pend_q;
    scan_d    = scan_q;
    here_d    = here_q;
    from_d    = from_q;
    jidx_d    = jidx_q;
    depth_d   = depth_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    last_d    = last_q;
    k_d       = k_q;
    status_d  = status_q;
    m_valid_d = m_valid_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    m_data_d  = m_data_q;

    edge_we     = 1'b0;
    edge_waddr  = wr_row_q;
    edge_wdata  = edge_row;
    edge_raddr  = erow_q;
    route_raddr = k_q;
    stk_we      = 1'b0;
    stk_waddr   = depth_q[NW-1:0];
    stk_wdata   = {here_q, from_q, jidx_q + KW'(1)};
    stk_raddr   = NW'(depth_q - KW'(1));
    push_en     = 1'b0;
    push_src    = here_q;
    push_dst    = jn;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == stw_pkg::OP_WRITE) begin
            wr_row_d   = s_axis_tdata[4:0];
            wr_col_d   = s_axis_tdata[9:5];
            wr_pos_d   = ($signed(s_axis_tdata[25:10]) > $signed(16'sd0));
            edge_raddr = s_axis_tdata[4:0];
            erow_d     = s_axis_tdata[4:0];
            state_d    = ST_WR_MOD;
          end else begin
            pend_d  = '0;
            scan_d  = '0;
            state_d = ST_PEND_RD;
          end
        end
      end
      // merge the edge bit into its row
      ST_WR_MOD: begin
        edge_we              = 1'b1;
        edge_wdata           = edge_row;
        edge_wdata[wr_col_q] = wr_pos_q;
        row_vld_d[wr_row_q]  = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_PEND_RD: begin
        edge_raddr = scan_q[NW-1:0];
        erow_d     = scan_q[NW-1:0];
        state_d    = ST_PEND_ACC;
      end
      // collect every node with an incoming edge, then open the root frame
      ST_PEND_ACC: begin
        pend_d = pend_q | edge_row;
        scan_d = scan_q + KW'(1);
        if (scan_q == KW'(MN - 1)) begin
          here_d     = '0;
          from_d     = '0;
          jidx_d     = '0;
          depth_d    = '0;
          cnt_d      = '0;
          seen_d     = '0;
          last_d     = '0;
          edge_raddr = '0;
          erow_d     = '0;
          state_d    = ST_LOAD;
        end else begin
          state_d = ST_PEND_RD;
        end
      end
      ST_LOAD: begin
        row_d   = edge_row;
        state_d = ST_SCAN;
      end
      // one column per cycle of the current frame
      ST_SCAN: begin
        if ((jidx_q >= n_act) || !room) begin
          if (depth_q == '0) begin
            status_d = (pend_q != '0) ? stw_pkg::STATUS_SPLIT : stw_pkg::STATUS_OK;
            k_d      = '0;
            if (cnt_q == '0) begin
              m_valid_d = 1'b1;
              m_user_d  = 1'b0;
              m_last_d  = 1'b1;
              m_data_d  = {5'd0,
                           ((pend_q != '0) ? stw_pkg::STATUS_SPLIT : stw_pkg::STATUS_OK),
                           17'd0};
              state_d   = ST_EM_WAIT;
            end else begin
              state_d = ST_EM_RD;
            end
          end else begin
            push_en  = room;
            push_src = here_q;
            push_dst = from_q;
            state_d  = ST_POP;
          end
        end else if (cand) begin
          push_en           = 1'b1;
          pend_d[here_q]    = 1'b0;
          pend_d[jn]        = 1'b0;
          if (depth_q + KW'(1) > n_act) begin
            state_d = ST_RET;
          end else begin
            stk_we     = 1'b1;
            here_d     = jn;
            from_d     = here_q;
            jidx_d     = '0;
            depth_d    = depth_q + KW'(1);
            edge_raddr = jn;
            erow_d     = jn;
            state_d    = ST_LOAD;
          end
        end else begin
          jidx_d = jidx_q + KW'(1);
        end
      end
      // return hop of a child beyond the depth limit
      ST_RET: begin
        push_en  = room;
        push_src = jn;
        push_dst = here_q;
        jidx_d   = jidx_q + KW'(1);
        state_d  = ST_SCAN;
      end
      // restore the parent frame
      ST_POP: begin
        here_d     = stk_rdata[stw_pkg::FRAME_W-1 -: NW];
        from_d     = stk_rdata[KW +: NW];
        jidx_d     = stk_rdata[KW-1:0];
        depth_d    = depth_q - KW'(1);
        edge_raddr = stk_rdata[stw_pkg::FRAME_W-1 -: NW];
        erow_d     = stk_rdata[stw_pkg::FRAME_W-1 -: NW];
        state_d    = ST_LOAD;
      end
      ST_EM_RD: begin
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        m_valid_d = 1'b1;
        m_user_d  = 1'b1;
        m_last_d  = (k_next == cnt_q);
        m_data_d  = {5'd0,
                     ((k_next == cnt_q) ? status_q : stw_pkg::STATUS_OK),
                     (k_q == last_q),
                     route_rdata[NW-1:0],
                     route_rdata[stw_pkg::HOP_W-1 -: NW],
                     k_q};
        state_d   = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          k_d       = k_next[SW-1:0];
          state_d   = m_last_q ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // record one hop and track the latest first visit
    if (push_en) begin
      cnt_d = cnt_q + CW'(1);
      if ((push_dst != '0) && !seen_q[push_dst]) begin
        seen_d[push_dst] = 1'b1;
        last_d           = cnt_q[SW-1:0];
      end
    end
  end

  assign route_we    = push_en;
  assign route_waddr = cnt_q[SW-1:0];
  assign route_wdata = {push_src, push_dst};

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= '0;
      row_vld_q <= '0;
      pend_q    <= '0;
      cnt_q     <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
      depth_q   <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      cfg_q     <= cfg_d;
      row_vld_q <= row_vld_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
      depth_q   <= depth_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_row_q <= wr_row_d;
    wr_col_q <= wr_col_d;
    wr_pos_q <= wr_pos_d;
    erow_q   <= erow_d;
    scan_q   <= scan_d;
    here_q   <= here_d;
    from_q   <= from_d;
    jidx_q   <= jidx_d;
    row_q    <= row_d;
    seen_q   <= seen_d;
    status_q <= status_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
    m_data_q <= m_data_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(stw_pkg::ROUTE_SLOTS))
    else $error("route count beyond list size");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_valid_q)
    else $error("input taken while a result waits");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (depth_q <= n_act))
    else $error("walk deeper than node limit");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> room)
    else $error("hop pushed into a full list");

endmodule
